// ===== hdl/jac_pkg.sv =====
// Shared types and constants for the four-point Jacobi stencil sweep.
// Configuration register codes, field widths and the per-cell descriptor.
// No dependencies.
package jac_pkg;

    localparam int CFG_ROWS_W  = 13;
    localparam int CFG_COLS_W  = 11;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_ROW_W   = 12;
    localparam int OUT_COL_W   = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLS = 1'b1;

    localparam logic [CFG_ROWS_W-1:0] GRID_ROWS_RESET = 13'd4096;
    localparam logic [CFG_COLS_W-1:0] GRID_COLS_RESET = 11'd1024;

    typedef struct packed {
        logic                 emit;
        logic                 last;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } cell_info_t;

endpackage

// ===== hdl/jacobi_4pt_stencil_sweep.sv =====
// Top level of the four-point Jacobi stencil sweep over a raster-order grid.
// Instantiates jac_raster, jac_linebuf and jac_average; depends on jac_pkg.
//
//  Group  Dir  Contents
//  s_     in   tdata: sample
//  m_     out  tdata: result_value, result_row, result_col; tlast: last_result
//  cfg_   in   write enable, index (0 grid_rows, 1 grid_cols), write data
//
// One request is taken per cycle while no stalled result holds the compute stage; the
// line buffer memory has two read ports and one write port.
// A request is registered in the compute stage, then the result of its cell in the output register.
// Reset clears the position and the window; the line buffers need no clearing.
// A stalled result holds the compute stage, and the input stalls behind it.
module jacobi_4pt_stencil_sweep
    import jac_pkg::*;
#(
    parameter int MAX_ROWS     = 4096,
    parameter int MAX_COLS     = 1024,
    parameter int SAMPLE_WIDTH = 32,
    localparam int S_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((SAMPLE_WIDTH + OUT_ROW_W + OUT_COL_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // result_value, result_row, result_col
    output logic                   m_tlast
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    cell_info_t            info;
    logic                  accept;
    logic [AW-1:0]         addr_a, addr_b;
    logic                  wr_en;
    logic [SAMPLE_WIDTH-1:0] wr_newer, up, moved, right, result_value;
    logic [OUT_ROW_W-1:0]  result_row;
    logic [OUT_COL_W-1:0]  result_col;

    jac_raster #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_raster (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .addr_a    (addr_a),
        .addr_b    (addr_b),
        .info      (info)
    );

    jac_linebuf #(
        .SW       (SAMPLE_WIDTH),
        .MAX_COLS (MAX_COLS)
    ) u_linebuf (
        .aclk     (aclk),
        .rd_en    (accept),
        .addr_a   (addr_a),
        .addr_b   (addr_b),
        .wr_en    (wr_en),
        .wr_newer (wr_newer),
        .up       (up),
        .moved    (moved),
        .right    (right)
    );

    jac_average #(
        .SW (SAMPLE_WIDTH)
    ) u_average (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .sample       (s_tdata[SAMPLE_WIDTH-1:0]),
        .info         (info),
        .accept       (accept),
        .up           (up),
        .moved        (moved),
        .right        (right),
        .wr_en        (wr_en),
        .wr_newer     (wr_newer),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .result_value (result_value),
        .result_row   (result_row),
        .result_col   (result_col),
        .last_result  (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({result_col, result_row, result_value});

endmodule

// ===== hdl/jac_raster.sv =====
// Raster position tracker and grid size registers for the stencil sweep.
// Produces line buffer addresses and the descriptor of the cell a sample closes.
// Depends on jac_pkg.
module jac_raster
    import jac_pkg::*;
#(
    parameter int MAX_ROWS = 4096,
    parameter int MAX_COLS = 1024,
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   accept,
    output logic [AW-1:0]          addr_a,
    output logic [AW-1:0]          addr_b,
    output cell_info_t             info
);

    localparam int EXT_W = AW + CFG_COLS_W;

    function automatic logic [CFG_ROWS_W-1:0] clamp_rows(input logic [CFG_ROWS_W-1:0] v);
        logic [CFG_ROWS_W-1:0] res;
        res = v;
        if (v < CFG_ROWS_W'(3)) begin
            res = CFG_ROWS_W'(3);
        end else if (32'(v) > MAX_ROWS) begin
            res = CFG_ROWS_W'(MAX_ROWS);
        end
        return res;
    endfunction

    function automatic logic [CFG_COLS_W-1:0] clamp_cols(input logic [CFG_COLS_W-1:0] v);
        logic [CFG_COLS_W-1:0] res;
        res = v;
        if (v < CFG_COLS_W'(3)) begin
            res = CFG_COLS_W'(3);
        end else if (32'(v) > MAX_COLS) begin
            res = CFG_COLS_W'(MAX_COLS);
        end
        return res;
    endfunction

    logic [CFG_ROWS_W-1:0] rows_reg;
    logic [CFG_COLS_W-1:0] cols_reg;
    logic [CFG_ROWS_W-1:0] row_reg, row_next;
    logic [CFG_COLS_W-1:0] col_reg, col_next;
    logic [CFG_ROWS_W-1:0] r0, r0_inc, r0_dec;
    logic [CFG_COLS_W-1:0] c0, c0_inc, c0_dec, widx;
    logic [EXT_W-1:0]      widx_ext, c0_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= clamp_rows(GRID_ROWS_RESET);
            cols_reg <= clamp_cols(GRID_COLS_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GRID_ROWS: rows_reg <= clamp_rows(cfg_wdata);
                CFG_GRID_COLS: cols_reg <= clamp_cols(cfg_wdata[CFG_COLS_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        c0 = col_reg;
        r0 = row_reg;
        if (c0 >= cols_reg) begin
            c0 = '0;
            r0 = row_reg + 1'b1;
        end
        if (r0 >= rows_reg) begin
            r0 = '0;
        end
        c0_inc = c0 + 1'b1;
        r0_inc = r0 + 1'b1;
        c0_dec = c0 - 1'b1;
        r0_dec = r0 - 1'b1;
        if (c0_inc >= cols_reg) begin
            col_next = '0;
            row_next = (r0_inc >= rows_reg) ? '0 : r0_inc;
        end else begin
            col_next = c0_inc;
            row_next = r0;
        end
        widx = (c0 == '0) ? (cols_reg - 1'b1) : c0_dec;
    end

    assign widx_ext = EXT_W'(widx);
    assign c0_ext   = EXT_W'(c0);
    assign addr_a   = widx_ext[AW-1:0];
    assign addr_b   = c0_ext[AW-1:0];

    assign info.emit = (r0 >= CFG_ROWS_W'(2)) && (c0 >= CFG_COLS_W'(2));
    assign info.last = (r0 == rows_reg - 1'b1) && (c0 == cols_reg - 1'b1);
    assign info.row  = r0_dec[OUT_ROW_W-1:0];
    assign info.col  = c0_dec[OUT_COL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // After a request taken with no configuration write, the position lies inside the grid in use.
    a_pos_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg_wr_en |=> (row_reg < rows_reg) && (col_reg < cols_reg))
        else $error("raster position left the grid");

endmodule

// ===== hdl/jac_linebuf.sv =====
// Line buffers of the stencil sweep: one memory holding the older and newer row
// per column, two registered read ports and one write port. Depends on nothing.
module jac_linebuf #(
    parameter int SW       = 32,
    parameter int MAX_COLS = 1024,
    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] addr_a,
    input  logic [AW-1:0] addr_b,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_newer,
    output logic [SW-1:0] up,
    output logic [SW-1:0] moved,
    output logic [SW-1:0] right
);

    logic [2*SW-1:0] mem [MAX_COLS];
    logic [2*SW-1:0] rd_a_reg;
    logic [SW-1:0]   rd_b_reg;
    logic [AW-1:0]   wa_reg;

    // Each entry is {older, newer}; a write shifts the newer row down into the older.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wa_reg] <= {rd_a_reg[SW-1:0], wr_newer};
        end
        if (rd_en) begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b][SW-1:0];
            wa_reg   <= addr_a;
        end
    end

    assign up    = rd_a_reg[2*SW-1:SW];
    assign moved = rd_a_reg[SW-1:0];
    assign right = rd_b_reg;

endmodule

// ===== hdl/jac_average.sv =====
// Compute stage and output register of the stencil sweep: four-neighbour sum,
// floor division by four, and the stream handshake. Depends on jac_pkg.
module jac_average
    import jac_pkg::*;
#(
    parameter int SW = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SW-1:0]        sample,
    input  cell_info_t           info,
    output logic                 accept,
    input  logic [SW-1:0]        up,
    input  logic [SW-1:0]        moved,
    input  logic [SW-1:0]        right,
    output logic                 wr_en,
    output logic [SW-1:0]        wr_newer,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SW-1:0]        result_value,
    output logic [OUT_ROW_W-1:0] result_row,
    output logic [OUT_COL_W-1:0] result_col,
    output logic                 last_result
);

    localparam int XW = SW + 2;

    logic                 s1_valid_reg;
    cell_info_t           s1_info_reg;
    logic [SW-1:0]        s1_down_reg;
    logic [SW-1:0]        prior_reg;
    logic [SW-1:0]        left_reg;
    logic                 s1_move;
    logic [XW-1:0]        sum;
    logic                 m_valid_reg;
    logic [SW-1:0]        m_value_reg;
    logic [OUT_ROW_W-1:0] m_row_reg;
    logic [OUT_COL_W-1:0] m_col_reg;
    logic                 m_last_reg;

    assign s1_move  = s1_valid_reg && (!s1_info_reg.emit || !m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_move;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = s1_move;
    assign wr_newer = s1_down_reg;

    assign sum = {{2{up[SW-1]}}, up} + {{2{s1_down_reg[SW-1]}}, s1_down_reg}
               + {{2{left_reg[SW-1]}}, left_reg} + {{2{right[SW-1]}}, right};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            prior_reg    <= '0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
                prior_reg    <= sample;
            end else if (s1_move) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg <= info;
            s1_down_reg <= prior_reg;
        end
        if (s1_move) begin
            left_reg <= moved;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move && s1_info_reg.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && s1_info_reg.emit) begin
            m_value_reg <= sum[XW-1:2];
            m_row_reg   <= s1_info_reg.row;
            m_col_reg   <= s1_info_reg.col;
            m_last_reg  <= s1_info_reg.last;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign result_value = m_value_reg;
    assign result_row   = m_row_reg;
    assign result_col   = m_col_reg;
    assign last_result  = m_last_reg;

    // A result only advances when the output register is free or being emptied.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_move && s1_info_reg.emit |-> !m_valid_reg || m_tready)
        else $error("result overwritten before it was taken");

    // The input side stalls only while the compute stage holds a request.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && !s1_move)
        else $error("input stalled without a held request");

    // A request taken is in the compute stage in the next cycle.
    a_stage_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("accepted request missing from compute stage");

endmodule

// ===== tb/jacobi_4pt_stencil_sweep_test.sv =====
// Self-checking testbench for the four-point Jacobi stencil sweep block.
// Streams raster-order grids through the block, predicts every interior cell
// and compares each result field; depends on jac_pkg and the block's RTL.
module jacobi_4pt_stencil_sweep_test;
    import jac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 1024;
    localparam int ROWS_LIMIT = 4096;
    localparam int M_W = ((32 + OUT_ROW_W + OUT_COL_W + 7) / 8) * 8;

    typedef struct packed {
        logic [31:0]          value;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } stencil_cell_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [31:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_W-1:0]         m_tdata;
    logic                   m_tlast;

    jacobi_4pt_stencil_sweep dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predictor state: two line buffers, the window sample and the raster position.
    logic [31:0] upper_line [LINE_DEPTH];
    logic [31:0] lower_line [LINE_DEPTH];
    logic [31:0] window_sample;
    int          row_pos;
    int          col_pos;
    int          rows_reg;
    int          cols_reg;

    stencil_cell_t expected_cells [$];
    stencil_cell_t want_cell;

    int failures;
    int samples_sent;
    int cells_checked;
    int settings_used;
    int src_idle_pct;
    int snk_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8ms;
        $display("FAIL jacobi_4pt_stencil_sweep");
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cells.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want_cell = expected_cells.pop_front();
                cells_checked++;
                if (m_tdata[31:0] !== want_cell.value) begin
                    failures++;
                    $display("%0t: result_value expected %h actual %h",
                             $time, want_cell.value, m_tdata[31:0]);
                end
                if (m_tdata[32 +: OUT_ROW_W] !== want_cell.row) begin
                    failures++;
                    $display("%0t: result_row expected %0d actual %0d",
                             $time, want_cell.row, m_tdata[32 +: OUT_ROW_W]);
                end
                if (m_tdata[32 + OUT_ROW_W +: OUT_COL_W] !== want_cell.col) begin
                    failures++;
                    $display("%0t: result_col expected %0d actual %0d",
                             $time, want_cell.col, m_tdata[32 + OUT_ROW_W +: OUT_COL_W]);
                end
                if (m_tlast !== want_cell.last) begin
                    failures++;
                    $display("%0t: last_result expected %b actual %b",
                             $time, want_cell.last, m_tlast);
                end
            end
        end
    end

    function automatic int clamp_size(input int v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advances the raster position by one sample and yields the interior cell it closes.
    function automatic bit stencil_step(input logic [31:0] x, output stencil_cell_t outcome);
        int               rows;
        int               cols;
        int               r;
        int               c;
        int               widx;
        bit               emit;
        logic [31:0]      up;
        logic [31:0]      left;
        logic [31:0]      right;
        logic signed [33:0] acc;

        rows = clamp_size(rows_reg, ROWS_LIMIT);
        cols = clamp_size(cols_reg, LINE_DEPTH);
        emit = 1'b0;
        outcome = '0;
        if (col_pos >= cols) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= rows) begin
            row_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        if (r >= 2 && c >= 2) begin
            up    = upper_line[c - 1];
            left  = upper_line[c - 2];
            right = lower_line[c];
            acc   = {{2{up[31]}}, up} + {{2{left[31]}}, left}
                  + {{2{right[31]}}, right} + {{2{window_sample[31]}}, window_sample};
            outcome.value = acc[33:2];
            outcome.row   = OUT_ROW_W'(r - 1);
            outcome.col   = OUT_COL_W'(c - 1);
            outcome.last  = (r == rows - 1) && (c == cols - 1);
            emit = 1'b1;
        end
        widx = (c == 0) ? cols - 1 : c - 1;
        upper_line[widx] = lower_line[widx];
        lower_line[widx] = window_sample;
        window_sample = x;
        col_pos = c + 1;
        if (col_pos >= cols) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= rows) begin
                row_pos = 0;
            end
        end
        return emit;
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(15))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'($urandom_range(7)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_sample(input logic [31:0] value);
        stencil_cell_t expected;

        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        samples_sent++;
        if (stencil_step(value, expected)) begin
            expected_cells.push_back(expected);
        end
    endtask

    // Holds the sender back until every outstanding result has been taken.
    task automatic wait_for_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_cells.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= CFG_DATA_W'(value);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_GRID_ROWS) begin
            rows_reg = value & ((1 << CFG_ROWS_W) - 1);
        end else begin
            cols_reg = value & ((1 << CFG_COLS_W) - 1);
        end
    endtask

    task automatic set_grid(input int rows_value, input int cols_value);
        wait_for_idle();
        write_reg(CFG_GRID_ROWS, rows_value);
        write_reg(CFG_GRID_COLS, cols_value);
        settings_used++;
    endtask

    task automatic complete_sweep();
        while (row_pos != 0 || col_pos != 0) begin
            push_sample(pick_sample());
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) push_sample(pick_sample());
    endtask

    // Smallest grid: all-maximum, all-minimum and a sum that floors towards minus infinity.
    task automatic test_minimum_grid();
        set_grid(0, 1);
        repeat (9) push_sample(32'h7fff_ffff);
        repeat (9) push_sample(32'h8000_0000);
        push_sample(32'h7fff_ffff);
        push_sample(32'hffff_ffff);
        push_sample(32'h7fff_ffff);
        push_sample(32'h0000_0000);
        push_sample(32'h8000_0000);
        push_sample(32'h0000_0000);
        push_sample(32'h7fff_ffff);
        push_sample(32'h0000_0000);
        push_sample(32'h7fff_ffff);
    endtask

    // Oversized row count clamped and undersized width clamped; the height is then cut
    // so that the sweep restarts and closes.
    task automatic test_tall_grid();
        set_grid(8191, 2);
        send_random(96);
        wait_for_idle();
        write_reg(CFG_GRID_ROWS, 3);
        settings_used++;
        complete_sweep();
    endtask

    // Oversized width clamped to the full line, then narrowed so the sweep closes on short rows.
    task automatic test_wide_grid();
        set_grid(1, 2047);
        send_random(LINE_DEPTH + 8);
        wait_for_idle();
        write_reg(CFG_GRID_COLS, 6);
        settings_used++;
        complete_sweep();
    endtask

    // Sizes changed part-way through a sweep: the position carries on, wraps a row or a sweep.
    task automatic test_resize_mid_sweep();
        set_grid(6, 8);
        send_random(21);
        wait_for_idle();
        write_reg(CFG_GRID_COLS, 4);
        send_random(6);
        wait_for_idle();
        write_reg(CFG_GRID_ROWS, 3);
        send_random(5);
        wait_for_idle();
        write_reg(CFG_GRID_COLS, 10);
        settings_used += 3;
        complete_sweep();
    endtask

    task automatic test_random_sweeps();
        int start;
        int rows_value;
        int cols_value;
        int cells;

        start = samples_sent;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        while (samples_sent - start < 500) begin
            if (samples_sent - start >= 200) begin
                src_idle_pct  = 30;
                snk_stall_pct = 30;
            end
            rows_value = ($urandom_range(9) == 0) ? $urandom_range(24, 3) : $urandom_range(8, 3);
            cols_value = ($urandom_range(19) == 0) ? $urandom_range(64, 17)
                                                   : $urandom_range(16, 3);
            if ($urandom_range(5) == 0) begin
                rows_value = $urandom_range(2);
            end
            if ($urandom_range(5) == 0) begin
                cols_value = $urandom_range(2);
            end
            set_grid(rows_value, cols_value);
            cells = clamp_size(rows_value, ROWS_LIMIT) * clamp_size(cols_value, LINE_DEPTH);
            if ($urandom_range(4) == 0) begin
                send_random($urandom_range(cells - 1, 1));
                wait_for_idle();
                if ($urandom_range(1) == 0) begin
                    write_reg(CFG_GRID_ROWS, $urandom_range(8, 3));
                end else begin
                    write_reg(CFG_GRID_COLS, $urandom_range(16, 3));
                end
                settings_used++;
                complete_sweep();
            end else begin
                repeat ((cells > 200) ? cells : $urandom_range(2, 1) * cells) begin
                    push_sample(pick_sample());
                    if ($urandom_range(199) == 0) begin
                        wait_for_idle();
                    end
                end
            end
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_GRID_ROWS;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        failures      = 0;
        samples_sent  = 0;
        cells_checked = 0;
        settings_used = 0;
        src_idle_pct  = 30;
        snk_stall_pct = 30;
        window_sample = '0;
        row_pos       = 0;
        col_pos       = 0;
        rows_reg      = GRID_ROWS_RESET;
        cols_reg      = GRID_COLS_RESET;
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_minimum_grid();
        test_tall_grid();
        test_wide_grid();
        test_resize_mid_sweep();
        test_random_sweeps();
        wait_for_idle();

        $display("Checked %0d interior cells from %0d samples over %0d grid settings.",
                 cells_checked, samples_sent, settings_used);
        $display("Grids ran from 3x3 up to clamped 4096-row and 1024-column sizes, with resizing.");
        if (failures == 0) begin
            $display("PASS jacobi_4pt_stencil_sweep");
        end else begin
            $display("FAIL jacobi_4pt_stencil_sweep");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jac_pkg.sv
hdl/jac_raster.sv
hdl/jac_linebuf.sv
hdl/jac_average.sv
hdl/jacobi_4pt_stencil_sweep.sv
tb/jacobi_4pt_stencil_sweep_test.sv
